// ===== design/whp_pkg.sv =====
// ----------------------------------------------------------------------------
// whp_pkg: shared types and constants of the WAVE header parser
// Item structs, parse phases, status codes and RIFF chunk identifiers.
// ----------------------------------------------------------------------------
package whp_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       first_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  bits_per_sample;
    logic        pcm_signed;
    logic [15:0] rate_lo;
  } out_item_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_RIFF = 4'd1,
    PH_WAVE = 4'd2,
    PH_FMTH = 4'd3,
    PH_FMTB = 4'd4,
    PH_NEXT = 4'd5,
    PH_FACT = 4'd6,
    PH_DATA = 4'd7,
    PH_DONE = 4'd8
  } phase_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_RIFF  = 3'd1;
  localparam logic [2:0] ST_NOT_WAVE  = 3'd2;
  localparam logic [2:0] ST_NO_FMT    = 3'd3;
  localparam logic [2:0] ST_TRUNCATED = 3'd4;
  localparam logic [2:0] ST_NOT_PCM   = 3'd5;
  localparam logic [2:0] ST_NOT_MONO  = 3'd6;
  localparam logic [2:0] ST_NO_DATA   = 3'd7;

  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;
  localparam logic [31:0] ID_FACT = 32'h7463_6166;

  localparam logic [31:0] OFS_CHAN = 32'h2;
  localparam logic [31:0] OFS_RATE = 32'h4;
  localparam logic [31:0] OFS_BITS = 32'hE;
  localparam logic [31:0] FMT_MIN  = 32'd16;
  localparam logic [31:0] HDR_SIZE_END = 32'd3;
  localparam logic [31:0] HDR_LAST     = 32'd7;

endpackage

// ===== design/whp_core.sv =====
// ----------------------------------------------------------------------------
// whp_core: byte-at-a-time RIFF/WAVE header state machine
// Updates the parse state on each accepted item and flags the final result.
// ----------------------------------------------------------------------------
module whp_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  whp_pkg::in_item_t  item,
  output logic               res_valid,
  output whp_pkg::out_item_t res_item
);
  import whp_pkg::*;

  phase_t      phase, phase_next;
  logic [31:0] byte_position, byte_position_next;
  logic [31:0] word_shift, word_shift_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [7:0]  sample_bits, sample_bits_next;
  logic [15:0] rate_low, rate_low_next;
  logic        pcm_seen, pcm_seen_next;
  logic        mono_seen, mono_seen_next;

  logic [31:0] ws_shift;
  logic [31:0] pos_inc;
  logic        hdr_phase;
  logic        hdr_done;
  logic        fin;
  logic [2:0]  fin_code;

  always_comb begin : next_state
    phase_next         = phase;
    byte_position_next = byte_position;
    word_shift_next    = word_shift;
    chunk_length_next  = chunk_length;
    sample_bits_next   = sample_bits;
    rate_low_next      = rate_low;
    pcm_seen_next      = pcm_seen;
    mono_seen_next     = mono_seen;
    ws_shift           = '0;
    pos_inc            = '0;
    hdr_phase          = 1'b0;
    hdr_done           = 1'b0;
    fin                = 1'b0;
    fin_code           = ST_OK;
    if (accept) begin
      // restart on a new file, then handle this byte as byte 0
      if (item.first_byte) begin
        phase_next         = PH_RIFF;
        byte_position_next = '0;
        word_shift_next    = '0;
        chunk_length_next  = '0;
        sample_bits_next   = '0;
        rate_low_next      = '0;
        pcm_seen_next      = 1'b0;
        mono_seen_next     = 1'b0;
      end
      ws_shift  = {item.byte_value, word_shift_next[31:8]};
      pos_inc   = byte_position_next + 32'd1;
      hdr_phase = (phase_next == PH_RIFF) || (phase_next == PH_FMTH) ||
                  (phase_next == PH_NEXT) || (phase_next == PH_DATA);
      priority if (phase_next == PH_IDLE || phase_next == PH_DONE) begin
        // ignore everything until the next file starts
      end else if (item.stream_end) begin
        fin = 1'b1;
        unique case (phase_next)
          PH_RIFF: fin_code = ST_NOT_RIFF;
          PH_WAVE: fin_code = ST_NOT_WAVE;
          PH_FMTH: fin_code = ST_NO_FMT;
          PH_FMTB: fin_code = ST_TRUNCATED;
          default: fin_code = ST_NO_DATA;
        endcase
      end else begin
        // eight-byte chunk header: id, then little-endian size
        if (hdr_phase) begin
          if (byte_position_next == HDR_SIZE_END) begin
            chunk_length_next = ws_shift;
          end
          if (byte_position_next == HDR_LAST) begin
            hdr_done           = 1'b1;
            word_shift_next    = chunk_length_next;
            chunk_length_next  = ws_shift;
            byte_position_next = '0;
          end else begin
            word_shift_next    = ws_shift;
            byte_position_next = pos_inc;
          end
        end
        unique case (phase_next)
          PH_RIFF: begin
            if (hdr_done) begin
              if (word_shift_next != ID_RIFF) begin
                fin      = 1'b1;
                fin_code = ST_NOT_RIFF;
              end else begin
                word_shift_next = '0;
                phase_next      = PH_WAVE;
              end
            end
          end
          PH_WAVE: begin
            word_shift_next = ws_shift;
            if (byte_position_next == HDR_SIZE_END) begin
              if (ws_shift != ID_WAVE) begin
                fin      = 1'b1;
                fin_code = ST_NOT_WAVE;
              end else begin
                byte_position_next = '0;
                word_shift_next    = '0;
                phase_next         = PH_FMTH;
              end
            end else begin
              byte_position_next = pos_inc;
            end
          end
          PH_FMTH: begin
            if (hdr_done) begin
              if (word_shift_next != ID_FMT) begin
                fin      = 1'b1;
                fin_code = ST_NO_FMT;
              end else if (chunk_length_next < FMT_MIN) begin
                fin      = 1'b1;
                fin_code = ST_TRUNCATED;
              end else begin
                phase_next = PH_FMTB;
              end
            end
          end
          PH_FMTB: begin
            if (byte_position_next == 32'd0) begin
              pcm_seen_next = (item.byte_value == 8'd1);
            end
            if (byte_position_next == 32'd1 && item.byte_value != 8'd0) begin
              pcm_seen_next = 1'b0;
            end
            if (byte_position_next == OFS_CHAN) begin
              mono_seen_next = (item.byte_value == 8'd1);
            end
            if (byte_position_next == OFS_CHAN + 32'd1 && item.byte_value != 8'd0) begin
              mono_seen_next = 1'b0;
            end
            if (byte_position_next == OFS_RATE) begin
              rate_low_next = {rate_low_next[15:8], item.byte_value};
            end
            if (byte_position_next == OFS_RATE + 32'd1) begin
              rate_low_next = {item.byte_value, rate_low_next[7:0]};
            end
            if (byte_position_next == OFS_BITS) begin
              sample_bits_next = item.byte_value;
            end
            if (pos_inc == chunk_length_next) begin
              if (!pcm_seen_next) begin
                fin      = 1'b1;
                fin_code = ST_NOT_PCM;
              end else if (!mono_seen_next) begin
                fin      = 1'b1;
                fin_code = ST_NOT_MONO;
              end else begin
                byte_position_next = '0;
                word_shift_next    = '0;
                phase_next         = PH_NEXT;
              end
            end else begin
              byte_position_next = pos_inc;
            end
          end
          PH_NEXT: begin
            if (hdr_done) begin
              if (word_shift_next == ID_DATA) begin
                fin      = 1'b1;
                fin_code = ST_OK;
              end else if (word_shift_next != ID_FACT) begin
                fin      = 1'b1;
                fin_code = ST_NO_DATA;
              end else begin
                word_shift_next = '0;
                phase_next      = (chunk_length_next == 32'd0) ? PH_DATA : PH_FACT;
              end
            end
          end
          PH_FACT: begin
            // skip the fact body by its stated size
            if (pos_inc == chunk_length_next) begin
              byte_position_next = '0;
              word_shift_next    = '0;
              phase_next         = PH_DATA;
            end else begin
              byte_position_next = pos_inc;
            end
          end
          PH_DATA: begin
            if (hdr_done) begin
              fin      = 1'b1;
              fin_code = (word_shift_next == ID_DATA) ? ST_OK : ST_NO_DATA;
            end
          end
          default: begin
          end
        endcase
      end
      if (fin) begin
        phase_next = PH_DONE;
      end
    end
  end

  always_comb begin : outputs
    res_valid                = fin;
    res_item.status          = fin_code;
    res_item.bits_per_sample = '0;
    res_item.pcm_signed      = 1'b0;
    res_item.rate_lo         = '0;
    if (fin_code == ST_OK) begin
      res_item.bits_per_sample = sample_bits_next;
      res_item.pcm_signed      = (sample_bits_next == 8'd16);
      res_item.rate_lo         = rate_low_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_position <= '0;
      word_shift    <= '0;
      chunk_length  <= '0;
      sample_bits   <= '0;
      rate_low      <= '0;
      pcm_seen      <= 1'b0;
      mono_seen     <= 1'b0;
    end else begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      word_shift    <= word_shift_next;
      chunk_length  <= chunk_length_next;
      sample_bits   <= sample_bits_next;
      rate_low      <= rate_low_next;
      pcm_seen      <= pcm_seen_next;
      mono_seen     <= mono_seen_next;
    end
  end

endmodule

// ===== design/wav_header_parser_top.sv =====
// ----------------------------------------------------------------------------
// wav_header_parser_top: RIFF/WAVE PCM header parser
// Streams file bytes in, reports one status item per file.
// ----------------------------------------------------------------------------
// Usage:
//   byte channel (byte_valid/byte_ready/byte_item): one file byte per item.
//   Set first_byte on byte 0 of a file to restart the parser; send an item
//   with stream_end set when the file runs out.
//   result channel (result_valid/result_ready/result_item): one item per
//   file, status 0 with the format fields, or an error code with zeros.
// Throughput: one byte item per cycle while byte_ready is high; the parse
//   core updates per byte; every byte is only shifted, compared and counted.
// Result path: a result is registered into the head entry, or into the skid
//   entry behind a full head, when the item that ends the header is accepted.
// Reset: parser goes idle and ignores bytes until first_byte; output empty.
// Stall: a two-entry output buffer (head register plus skid) holds results;
//   byte_ready drops only while both entries are full.
// ----------------------------------------------------------------------------
module wav_header_parser_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_ready,
  input  whp_pkg::in_item_t  byte_item,
  output logic               result_valid,
  input  logic               result_ready,
  output whp_pkg::out_item_t result_item
);
  import whp_pkg::*;

  logic      accept;
  logic      core_valid;
  out_item_t core_item;
  logic      pop;

  logic      head_valid;
  logic      skid_valid;
  out_item_t head_item;
  out_item_t skid_item;

  // take a byte whenever the skid entry is free
  assign byte_ready = !skid_valid;
  assign accept     = byte_valid && byte_ready;
  assign pop        = result_valid && result_ready;

  whp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (byte_item),
    .res_valid (core_valid),
    .res_item  (core_item)
  );

  // occupancy of the head and skid entries
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      priority if (skid_valid) begin
        // drain the skid into the head; head stays full
        if (pop) begin
          skid_valid <= 1'b0;
        end
      end else if (head_valid) begin
        if (core_valid && !pop) begin
          skid_valid <= 1'b1;
        end else if (!core_valid && pop) begin
          head_valid <= 1'b0;
        end
      end else begin
        head_valid <= core_valid;
      end
    end
  end

  // payload moves, no reset needed
  always_ff @(posedge clk) begin
    priority if (skid_valid) begin
      if (pop) begin
        head_item <= skid_item;
      end
    end else if (head_valid) begin
      if (core_valid) begin
        if (pop) begin
          head_item <= core_item;
        end else begin
          skid_item <= core_item;
        end
      end
    end else begin
      if (core_valid) begin
        head_item <= core_item;
      end
    end
  end

  assign result_valid = head_valid;
  assign result_item  = head_item;

`ifndef SYNTHESIS
  // a new result never lands while the skid entry is occupied
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    core_valid |-> !skid_valid)
    else $error("result produced while output buffer full");

  // the skid entry is only used behind a full head entry
  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> head_valid)
    else $error("skid entry valid without head entry");

  // draining from a full buffer leaves a result on the port
  a_drain_keeps_head: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && pop) |=> result_valid)
    else $error("result lost when draining skid entry");
`endif

endmodule
